// File: hdl/rsfu_pkg.sv
`default_nettype none

package rsfu_pkg;

   localparam int WORD_BITS = 16;
   localparam int TOP_BIT   = WORD_BITS - 1;

   localparam logic [WORD_BITS-1:0] LOW_BYTE_MASK  = 16'h00FF;
   localparam logic [WORD_BITS-1:0] HIGH_BYTE_MASK = 16'hFF00;

   typedef enum logic [3:0] {
      FUNC_ZLB = 4'd0,
      FUNC_ZRB = 4'd1,
      FUNC_SXU = 4'd2,
      FUNC_SXL = 4'd3,
      FUNC_SLZ = 4'd4,
      FUNC_SLY = 4'd5,
      FUNC_SLX = 4'd6,
      FUNC_SVZ = 4'd7,
      FUNC_SVY = 4'd8,
      FUNC_SVX = 4'd9,
      FUNC_SRY = 4'd10,
      FUNC_SRX = 4'd11,
      FUNC_SRZ = 4'd12,
      FUNC_SHC = 4'd13
   } func_type;

   typedef struct packed {
      logic [3:0]           func;
      logic [WORD_BITS-1:0] a_value;
      logic [3:0]           shift_count;
      logic                 y_in;
      logic                 x_in;
      logic                 z_in;
      logic                 v_in;
   } req_item_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] result_value;
      logic                 y_out;
      logic                 x_out;
      logic                 z_out;
      logic                 v_out;
   } rsp_item_type;

endpackage

`default_nettype wire

// File: hdl/rsfu_alu.sv
`default_nettype none

// Shift / rotate / byte-clear / test datapath, purely combinational.
module rsfu_alu (
   input  wire rsfu_pkg::req_item_type req_item,
   output rsfu_pkg::rsp_item_type      rsp_item
);

   logic [rsfu_pkg::WORD_BITS-1:0]   a;
   logic [2*rsfu_pkg::WORD_BITS-1:0] rot_wide;
   logic                             fill;
   logic                             ovf_form;
   logic [rsfu_pkg::WORD_BITS-1:0]   r;
   logic                             y;
   logic                             x;
   logic                             z;

   assign a        = req_item.a_value;
   // count 0 falls out naturally: low half of {a,a} is a
   assign rot_wide = {a, a} >> req_item.shift_count;

   always_comb begin
      r        = a;
      y        = req_item.y_in;
      x        = req_item.x_in;
      z        = req_item.z_in;
      fill     = 1'b0;
      ovf_form = 1'b0;
      case (rsfu_pkg::func_type'(req_item.func))
         rsfu_pkg::FUNC_ZLB: r = a & rsfu_pkg::LOW_BYTE_MASK;
         rsfu_pkg::FUNC_ZRB: r = a & rsfu_pkg::HIGH_BYTE_MASK;
         rsfu_pkg::FUNC_SXU: begin
            x = a[rsfu_pkg::TOP_BIT];
            z = (a == '0);
         end
         rsfu_pkg::FUNC_SXL: begin
            x = a[0];
            z = (a == '0);
         end
         rsfu_pkg::FUNC_SLZ, rsfu_pkg::FUNC_SLY, rsfu_pkg::FUNC_SLX,
         rsfu_pkg::FUNC_SVZ, rsfu_pkg::FUNC_SVY, rsfu_pkg::FUNC_SVX: begin
            if ((rsfu_pkg::func_type'(req_item.func) == rsfu_pkg::FUNC_SLY) ||
                (rsfu_pkg::func_type'(req_item.func) == rsfu_pkg::FUNC_SVY)) begin
               fill = req_item.y_in;
            end else if ((rsfu_pkg::func_type'(req_item.func) == rsfu_pkg::FUNC_SLX) ||
                         (rsfu_pkg::func_type'(req_item.func) == rsfu_pkg::FUNC_SVX)) begin
               fill = req_item.x_in;
            end
            ovf_form = (rsfu_pkg::func_type'(req_item.func) == rsfu_pkg::FUNC_SVZ) ||
                       (rsfu_pkg::func_type'(req_item.func) == rsfu_pkg::FUNC_SVY) ||
                       (rsfu_pkg::func_type'(req_item.func) == rsfu_pkg::FUNC_SVX);
            y = a[rsfu_pkg::TOP_BIT];
            r = {a[rsfu_pkg::TOP_BIT-1:0], fill};
         end
         rsfu_pkg::FUNC_SRY, rsfu_pkg::FUNC_SRX, rsfu_pkg::FUNC_SRZ: begin
            if (rsfu_pkg::func_type'(req_item.func) == rsfu_pkg::FUNC_SRY) begin
               fill = req_item.y_in;
            end else if (rsfu_pkg::func_type'(req_item.func) == rsfu_pkg::FUNC_SRX) begin
               fill = req_item.x_in;
            end
            y = a[0];
            r = {fill, a[rsfu_pkg::TOP_BIT:1]};
         end
         rsfu_pkg::FUNC_SHC: r = rot_wide[rsfu_pkg::WORD_BITS-1:0];
         default: ;  // unused codes pass everything through
      endcase
   end

   assign rsp_item.result_value = r;
   assign rsp_item.y_out        = y;
   assign rsp_item.x_out        = x;
   assign rsp_item.z_out        = z;
   // sticky V: set when bit 15 flips on the overflow-checking shifts
   assign rsp_item.v_out        = req_item.v_in |
                                  (ovf_form & (a[rsfu_pkg::TOP_BIT] ^ r[rsfu_pkg::TOP_BIT]));

endmodule

`default_nettype wire

// File: hdl/register_shift_flag_unit_core.sv
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+----------------------------------------
// req      | in        | req_valid/req_stall | func, a_value, shift_count, y/x/z/v_in
// rsp      | out       | rsp_valid/rsp_stall | result_value, y/x/z/v_out
//
// The item is captured in the input register, the datapath works on it,
// and the result lands in the output register.
// One item per cycle is sustained; the only limit is a stalled output register.
// Reset (synchronous, active high) empties both stages.
// req_stall rises only when both stages hold items and rsp_stall is high.
module register_shift_flag_unit_core (
   input  wire                             clock,
   input  wire                             reset,

   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire  [3:0]                      req_func,
   input  wire  [rsfu_pkg::WORD_BITS-1:0]  req_a_value,
   input  wire  [3:0]                      req_shift_count,
   input  wire                             req_y_in,
   input  wire                             req_x_in,
   input  wire                             req_z_in,
   input  wire                             req_v_in,

   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic [rsfu_pkg::WORD_BITS-1:0]  rsp_result_value,
   output logic                            rsp_y_out,
   output logic                            rsp_x_out,
   output logic                            rsp_z_out,
   output logic                            rsp_v_out
);

   // input stage
   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   rsfu_pkg::req_item_type  s1_item_ff;
   rsfu_pkg::req_item_type  req_item;

   // output stage
   logic                    out_valid_ff;
   logic                    out_valid_in;
   rsfu_pkg::rsp_item_type  out_item_ff;
   rsfu_pkg::rsp_item_type  alu_item;

   logic                    out_ready;
   logic                    s1_ready;
   logic                    req_take;

   assign req_item.func        = req_func;
   assign req_item.a_value     = req_a_value;
   assign req_item.shift_count = req_shift_count;
   assign req_item.y_in        = req_y_in;
   assign req_item.x_in        = req_x_in;
   assign req_item.z_in        = req_z_in;
   assign req_item.v_in        = req_v_in;

   // Output register can load when empty or being drained this cycle.
   assign out_ready = !out_valid_ff || !rsp_stall;
   // Input register can load when empty or its item moves on.
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign req_stall = !s1_ready;
   assign req_take  = req_valid && s1_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_ready) begin
         s1_valid_in = req_valid;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_ready) begin
         out_valid_in = s1_valid_ff;
      end
   end

   rsfu_alu u_alu (
      .req_item (s1_item_ff),
      .rsp_item (alu_item)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_item;
      end
      if (out_ready && s1_valid_ff) begin
         out_item_ff <= alu_item;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_value = out_item_ff.result_value;
   assign rsp_y_out        = out_item_ff.y_out;
   assign rsp_x_out        = out_item_ff.x_out;
   assign rsp_z_out        = out_item_ff.z_out;
   assign rsp_v_out        = out_item_ff.v_out;

endmodule

`default_nettype wire

// File: hdl/rsfu_checker.sv
`default_nettype none

module rsfu_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_valid,
   input wire                            req_stall,
   input wire                            rsp_valid,
   input wire                            rsp_stall,
   input wire [rsfu_pkg::WORD_BITS-1:0]  rsp_result_value,
   input wire                            rsp_y_out,
   input wire                            rsp_x_out,
   input wire                            rsp_z_out,
   input wire                            rsp_v_out
);

   // both stages are empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high after reset");

   // backpressure on req only comes from a stalled, full output
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without downstream stall");

   // an accepted item reaches the output register when the output can move
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 (!rsp_valid || !rsp_stall) |=> rsp_valid)
      else $error("item lost in pipeline");

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_result_value) &&
         $stable(rsp_y_out) && $stable(rsp_x_out) && $stable(rsp_z_out) &&
         $stable(rsp_v_out)))
      else $error("stalled item changed");

endmodule

bind register_shift_flag_unit_core rsfu_checker u_rsfu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_value (rsp_result_value),
   .rsp_y_out        (rsp_y_out),
   .rsp_x_out        (rsp_x_out),
   .rsp_z_out        (rsp_z_out),
   .rsp_v_out        (rsp_v_out)
);

`default_nettype wire

// File: bench/testbench.sv
`default_nettype none

// Bench for the register shift/flag unit.
// - Each test task builds items and hands them to send_item, which waits out a
//   random gap, offers the item, and on acceptance queues the predicted result.
// - The result side runs in its own always block: it draws a stall per item,
//   compares every accepted result with the oldest prediction, and flags
//   results that arrive with nothing queued.
// - A separate counter holds the result side off for a long stretch on request,
//   so the two pipeline stages fill up and req_stall has to rise.
module testbench;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 10;   // leave some slack after the queue empties
   localparam int PRINT_LIMIT = 50;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [3:0]                     req_func = '0;
   logic [rsfu_pkg::WORD_BITS-1:0] req_a_value = '0;
   logic [3:0]                     req_shift_count = '0;
   logic                           req_y_in = 1'b0;
   logic                           req_x_in = 1'b0;
   logic                           req_z_in = 1'b0;
   logic                           req_v_in = 1'b0;

   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [rsfu_pkg::WORD_BITS-1:0] rsp_result_value;
   logic                           rsp_y_out;
   logic                           rsp_x_out;
   logic                           rsp_z_out;
   logic                           rsp_v_out;

   register_shift_flag_unit_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_a_value      (req_a_value),
      .req_shift_count  (req_shift_count),
      .req_y_in         (req_y_in),
      .req_x_in         (req_x_in),
      .req_z_in         (req_z_in),
      .req_v_in         (req_v_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_y_out        (rsp_y_out),
      .rsp_x_out        (rsp_x_out),
      .rsp_z_out        (rsp_z_out),
      .rsp_v_out        (rsp_v_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted results, oldest first.
   rsfu_pkg::rsp_item_type expected_results[$];

   int mismatch_count = 0;
   int cycle_count = 0;

   // Idle knobs: upper bound of the random gap per item on each side.
   int req_gap_max = 4;
   int rsp_wait_max = 4;

   // Long result-side hold, counted down by its own process.
   int hold_left = 0;
   int stall_budget = 0;

   // ------------------------------------------------------------------
   // Predictor: new register value and flags for one item.
   // ------------------------------------------------------------------
   function automatic rsfu_pkg::rsp_item_type shift_unit_predict(
      input rsfu_pkg::req_item_type it);
      rsfu_pkg::rsp_item_type res;
      logic [2*rsfu_pkg::WORD_BITS-1:0] doubled;
      logic fill;
      logic sign_check;
      res.result_value = it.a_value;
      res.y_out = it.y_in;
      res.x_out = it.x_in;
      res.z_out = it.z_in;
      res.v_out = it.v_in;
      sign_check = 1'b0;
      fill = 1'b0;
      case (it.func)
         rsfu_pkg::FUNC_ZLB: res.result_value = it.a_value & rsfu_pkg::LOW_BYTE_MASK;
         rsfu_pkg::FUNC_ZRB: res.result_value = it.a_value & rsfu_pkg::HIGH_BYTE_MASK;
         rsfu_pkg::FUNC_SXU: begin
            res.x_out = it.a_value[rsfu_pkg::TOP_BIT];
            res.z_out = (it.a_value == '0);
         end
         rsfu_pkg::FUNC_SXL: begin
            res.x_out = it.a_value[0];
            res.z_out = (it.a_value == '0);
         end
         rsfu_pkg::FUNC_SLZ, rsfu_pkg::FUNC_SLY, rsfu_pkg::FUNC_SLX,
         rsfu_pkg::FUNC_SVZ, rsfu_pkg::FUNC_SVY, rsfu_pkg::FUNC_SVX: begin
            if (it.func == rsfu_pkg::FUNC_SLY || it.func == rsfu_pkg::FUNC_SVY)
               fill = it.y_in;
            if (it.func == rsfu_pkg::FUNC_SLX || it.func == rsfu_pkg::FUNC_SVX)
               fill = it.x_in;
            sign_check = (it.func == rsfu_pkg::FUNC_SVZ || it.func == rsfu_pkg::FUNC_SVY ||
                          it.func == rsfu_pkg::FUNC_SVX);
            // old top bit goes out into Y
            res.y_out = it.a_value[rsfu_pkg::TOP_BIT];
            res.result_value = {it.a_value[rsfu_pkg::TOP_BIT-1:0], fill};
         end
         rsfu_pkg::FUNC_SRY, rsfu_pkg::FUNC_SRX, rsfu_pkg::FUNC_SRZ: begin
            if (it.func == rsfu_pkg::FUNC_SRY) fill = it.y_in;
            if (it.func == rsfu_pkg::FUNC_SRX) fill = it.x_in;
            res.y_out = it.a_value[0];
            res.result_value = {fill, it.a_value[rsfu_pkg::TOP_BIT:1]};
         end
         rsfu_pkg::FUNC_SHC: begin
            // rotate right: shift the doubled word, keep the low half
            doubled = {it.a_value, it.a_value} >> it.shift_count;
            res.result_value = doubled[rsfu_pkg::WORD_BITS-1:0];
         end
         default: ;   // unused codes pass everything through
      endcase
      // sticky V: set when bit 15 flips on the overflow forms
      if (sign_check &&
          (it.a_value[rsfu_pkg::TOP_BIT] != res.result_value[rsfu_pkg::TOP_BIT]))
         res.v_out = 1'b1;
      return res;
   endfunction

   task automatic note_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("[%0d] mismatch: %s", cycle_count, what);
      end
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Sender: random gap, offer, wait for the handshake, queue prediction.
   // valid is only lowered when a gap follows, so back-to-back items keep
   // it high without a lower/raise in one step.
   // ------------------------------------------------------------------
   task automatic send_item(input rsfu_pkg::req_item_type it);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= it.func;
      req_a_value     <= it.a_value;
      req_shift_count <= it.shift_count;
      req_y_in        <= it.y_in;
      req_x_in        <= it.x_in;
      req_z_in        <= it.z_in;
      req_v_in        <= it.v_in;
      do @(posedge clock); while (!(req_valid && !req_stall));
      expected_results.push_back(shift_unit_predict(it));
   endtask

   // Word with a bias toward the sign and byte corners.
   function automatic logic [rsfu_pkg::WORD_BITS-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         default: return rsfu_pkg::WORD_BITS'($urandom);
      endcase
   endfunction

   function automatic rsfu_pkg::req_item_type random_item();
      rsfu_pkg::req_item_type it;
      // unused codes only now and then; they merely pass through
      if ($urandom_range(0, 19) == 0) it.func = 4'($urandom_range(14, 15));
      else it.func = 4'($urandom_range(rsfu_pkg::FUNC_ZLB, rsfu_pkg::FUNC_SHC));
      it.a_value     = pick_word();
      it.shift_count = 4'($urandom_range(0, 15));
      it.y_in        = 1'($urandom);
      it.x_in        = 1'($urandom);
      it.z_in        = 1'($urandom);
      it.v_in        = 1'($urandom);
      return it;
   endfunction

   function automatic rsfu_pkg::req_item_type make_item(
      input logic [3:0] func,
      input logic [rsfu_pkg::WORD_BITS-1:0] a,
      input logic [3:0] cnt,
      input logic [3:0] yxzv);
      rsfu_pkg::req_item_type it;
      it.func = func;
      it.a_value = a;
      it.shift_count = cnt;
      {it.y_in, it.x_in, it.z_in, it.v_in} = yxzv;
      return it;
   endfunction

   // ------------------------------------------------------------------
   // Result side: per-item stall draw, long hold, and the field checks.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsfu_pkg::rsp_item_type want;
      if (rsp_valid && !rsp_stall && !reset) begin
         if (expected_results.size() == 0) begin
            note_mismatch($sformatf("result %h with nothing expected", rsp_result_value));
         end else begin
            want = expected_results.pop_front();
            if (rsp_result_value !== want.result_value)
               note_mismatch($sformatf("value got %h want %h",
                                       rsp_result_value, want.result_value));
            if (rsp_y_out !== want.y_out)
               note_mismatch($sformatf("Y got %b want %b", rsp_y_out, want.y_out));
            if (rsp_x_out !== want.x_out)
               note_mismatch($sformatf("X got %b want %b", rsp_x_out, want.x_out));
            if (rsp_z_out !== want.z_out)
               note_mismatch($sformatf("Z got %b want %b", rsp_z_out, want.z_out));
            if (rsp_v_out !== want.v_out)
               note_mismatch($sformatf("V got %b want %b", rsp_v_out, want.v_out));
         end
         stall_budget = $urandom_range(0, rsp_wait_max);
      end
      if (hold_left > 0 || stall_budget > 0) begin
         rsp_stall <= 1'b1;
         if (stall_budget > 0) stall_budget--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Long hold countdown; the pressure test loads it while it is zero.
   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Every operation, field extremes, zero rotate, unused codes,
   // sticky V and the fill bit on the overflow forms.
   task automatic run_directed_cases();
      send_item(make_item(rsfu_pkg::FUNC_ZLB, 16'hFFFF, 4'd0, 4'b0000));
      send_item(make_item(rsfu_pkg::FUNC_ZRB, 16'hFFFF, 4'd0, 4'b1111));
      send_item(make_item(rsfu_pkg::FUNC_SXU, 16'h0000, 4'd0, 4'b0100));
      send_item(make_item(rsfu_pkg::FUNC_SXU, 16'h8000, 4'd0, 4'b0010));
      send_item(make_item(rsfu_pkg::FUNC_SXL, 16'h0001, 4'd0, 4'b0010));
      send_item(make_item(rsfu_pkg::FUNC_SXL, 16'h0000, 4'd0, 4'b1101));
      send_item(make_item(rsfu_pkg::FUNC_SLZ, 16'h8000, 4'd0, 4'b0000));
      send_item(make_item(rsfu_pkg::FUNC_SLY, 16'hFFFF, 4'd0, 4'b1000));
      send_item(make_item(rsfu_pkg::FUNC_SLX, 16'h7FFF, 4'd0, 4'b0100));
      send_item(make_item(rsfu_pkg::FUNC_SVZ, 16'h4000, 4'd0, 4'b0000));
      send_item(make_item(rsfu_pkg::FUNC_SVZ, 16'hC000, 4'd0, 4'b0000));
      // fill of 1 must not decide V
      send_item(make_item(rsfu_pkg::FUNC_SVY, 16'h7FFF, 4'd0, 4'b1000));
      send_item(make_item(rsfu_pkg::FUNC_SVX, 16'h8000, 4'd0, 4'b0100));
      // V stays set when no sign change
      send_item(make_item(rsfu_pkg::FUNC_SVZ, 16'h0000, 4'd0, 4'b0001));
      send_item(make_item(rsfu_pkg::FUNC_SRY, 16'h0001, 4'd0, 4'b1000));
      send_item(make_item(rsfu_pkg::FUNC_SRX, 16'hFFFF, 4'd0, 4'b1011));
      send_item(make_item(rsfu_pkg::FUNC_SRZ, 16'hFFFF, 4'd0, 4'b1111));
      send_item(make_item(rsfu_pkg::FUNC_SHC, 16'h1234, 4'd0, 4'b0000));
      send_item(make_item(rsfu_pkg::FUNC_SHC, 16'h8001, 4'd15, 4'b1010));
      send_item(make_item(rsfu_pkg::FUNC_SHC, 16'h0001, 4'd1, 4'b0101));
      send_item(make_item(rsfu_pkg::FUNC_SHC, 16'hABCD, 4'd8, 4'b0000));
      send_item(make_item(4'd14, 16'h5A5A, 4'd7, 4'b1111));
      send_item(make_item(4'd15, 16'hA5A5, 4'd15, 4'b0000));
   endtask

   task automatic run_random_mix(input int count);
      for (int i = 0; i < count; i++) send_item(random_item());
   endtask

   // No idling on either side: one item per cycle.
   task automatic run_streaming(input int count);
      req_gap_max = 0;
      rsp_wait_max = 0;
      for (int i = 0; i < count; i++) send_item(random_item());
      req_gap_max = 4;
      rsp_wait_max = 4;
   endtask

   // Hold the result side off while items keep coming: the block fills
   // and must stall its input without losing or reordering anything.
   task automatic run_output_hold(input int hold, input int count);
      req_gap_max = 0;
      rsp_wait_max = 0;
      hold_left <= hold;
      for (int i = 0; i < count; i++) send_item(random_item());
      req_gap_max = 4;
      rsp_wait_max = 4;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      run_directed_cases();
      run_random_mix(450);
      run_streaming(300);
      run_output_hold(80, 40);
      run_random_mix(200);
      run_output_hold(120, 30);
      run_random_mix(80);

      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: register_shift_flag_unit_core.f
hdl/rsfu_pkg.sv
hdl/rsfu_alu.sv
hdl/register_shift_flag_unit_core.sv
hdl/rsfu_checker.sv
bench/testbench.sv
